>>> rtl/core/fbs_pkg.sv
// package for the forward bilinear splat unit
// types, constants and command codes; no dependencies
package fbs_pkg;
  localparam int StoreRows = 256;
  localparam int StoreCols = 256;
  localparam int FracBits = 8;
  localparam int RowBits = $clog2(StoreRows);
  localparam int ColBits = $clog2(StoreCols);
  localparam int AddrBits = RowBits + ColBits;
  localparam int Depth = StoreRows * StoreCols;
  localparam int WBits = 24;
  localparam int VBits = 32;
  localparam int EntBits = WBits + VBits;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 9;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_SPLAT = 2'd0,
    CMD_READ = 2'd1,
    CMD_READ_CLR = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_TWEEN = 3'd0,
    REG_LEFT = 3'd1,
    REG_TOP = 3'd2,
    REG_WIDTH = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } back_state_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic        splat;
    logic        rd;
    logic        clr;
    logic        valid_addr;
    logic [AddrBits-1:0] base;
    logic [7:0]  pixel;
    logic [16:0] w00;
    logic [16:0] w01;
    logic [16:0] w11;
    logic [16:0] w10;
  } op_t;

  function automatic logic [16:0] to_q16(input logic [2*FracBits-1:0] raw);
    logic [31:0] r;
    r = 32'(raw);
    if (2 * FracBits >= 16) to_q16 = 17'(r >> (2 * FracBits - 16));
    else to_q16 = 17'(r << (16 - 2 * FracBits));
  endfunction
endpackage

>>> rtl/core/fbs_if.sv
// valid/ready channel interfaces for the splat unit
// no dependencies
interface fbs_in_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  modport source (output valid, command, row, col, pixel, flow_x, flow_y, input ready);
  modport sink (input valid, command, row, col, pixel, flow_x, flow_y, output ready);
endinterface

interface fbs_out_if;
  logic valid;
  logic ready;
  logic landed;
  logic [23:0] weight_sum;
  logic [31:0] value_sum;
  modport source (output valid, landed, weight_sum, value_sum, input ready);
  modport sink (input valid, landed, weight_sum, value_sum, output ready);
endinterface

>>> rtl/core/fbs_ram.sv
// generic single-port ram with registered read
// no dependencies
module fbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/fbs_front.sv
// front end: target computation, window check, weights
// depends on fbs_pkg
module fbs_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  input  logic [7:0] in_pixel,
  input  logic signed [15:0] in_flow_x,
  input  logic signed [15:0] in_flow_y,
  input  logic [8:0] tween_r,
  input  logic [7:0] left_r,
  input  logic [7:0] top_r,
  input  logic [8:0] width_r,
  input  logic [8:0] height_r,
  output logic   op_valid,
  input  logic   op_ready,
  output fbs_pkg::op_t op
);
  import fbs_pkg::*;
  // stage 1: multiply, registered
  logic s1_v_r;
  logic [1:0] s1_cmd_r;
  logic [7:0] s1_row_r, s1_col_r, s1_pix_r;
  logic signed [25:0] s1_py_r, s1_px_r;
  logic s1_ld;
  logic signed [25:0] pr_y, pr_x;
  assign pr_y = 26'(in_flow_y) * $signed({1'b0, tween_r});
  assign pr_x = 26'(in_flow_x) * $signed({1'b0, tween_r});
  assign s1_ld = !s1_v_r || op_ready;
  assign in_ready = s1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_ld) s1_v_r <= in_valid;
    if (s1_ld && in_valid) begin
      s1_cmd_r <= in_command;
      s1_row_r <= in_row;
      s1_col_r <= in_col;
      s1_pix_r <= in_pixel;
      s1_py_r <= pr_y;
      s1_px_r <= pr_x;
    end
  end

  // stage 2: floor and classify (combinational into op)
  logic signed [26:0] ty, tx;
  logic signed [26-16+FracBits:0] py, px;
  logic signed [26-16:0] jt, kt;
  logic [FracBits-1:0] yf, xf;
  logic [FracBits:0] one;
  logic [2*FracBits+1:0] m00, m01, m11, m10;
  logic in_win;
  assign ty = $signed({1'b0, s1_row_r, 16'd0}) - 27'(s1_py_r);
  assign tx = $signed({1'b0, s1_col_r, 16'd0}) - 27'(s1_px_r);
  assign py = ty[26:16-FracBits];
  assign px = tx[26:16-FracBits];
  assign jt = py[26-16+FracBits:FracBits];
  assign kt = px[26-16+FracBits:FracBits];
  assign yf = py[FracBits-1:0];
  assign xf = px[FracBits-1:0];
  assign one = (FracBits+1)'(1) << FracBits;
  assign m00 = (2*FracBits+2)'((one - xf) * (one - yf));
  assign m01 = (2*FracBits+2)'(xf * (one - yf));
  assign m11 = (2*FracBits+2)'(xf * yf);
  assign m10 = (2*FracBits+2)'((one - xf) * yf);
  assign in_win = (jt >= $signed({3'b0, top_r}))
    && (jt < $signed({2'b0, top_r} + {2'b0, height_r}) - 11'sd1)
    && (kt >= $signed({3'b0, left_r}))
    && (kt < $signed({2'b0, left_r} + {2'b0, width_r}) - 11'sd1)
    && (jt + 11'sd1 < 11'(StoreRows)) && (kt + 11'sd1 < 11'(StoreCols));

  always_comb begin
    op = '0;
    op.pixel = s1_pix_r;
    op.splat = (s1_cmd_r == CMD_SPLAT) && in_win;
    op.rd = (s1_cmd_r == CMD_READ) || (s1_cmd_r == CMD_READ_CLR);
    op.clr = (s1_cmd_r == CMD_READ_CLR);
    op.valid_addr = (32'(s1_row_r) < StoreRows) && (32'(s1_col_r) < StoreCols);
    if (op.splat) op.base = {jt[RowBits-1:0], kt[ColBits-1:0]};
    else op.base = {s1_row_r[RowBits-1:0], s1_col_r[ColBits-1:0]};
    // full weight needs 17 bits when raw fraction is zero
    op.w00 = to_q16((2*FracBits)'(m00)) | ((m00[2*FracBits]) ? 17'h10000 : 17'h0);
    op.w01 = to_q16((2*FracBits)'(m01));
    op.w11 = to_q16((2*FracBits)'(m11));
    op.w10 = to_q16((2*FracBits)'(m10));
  end
  assign op_valid = s1_v_r;
endmodule

>>> rtl/core/fbs_back.sv
// back end: read-modify-write sequencer over the sum store
// depends on fbs_pkg, fbs_ram
module fbs_back (
  input  logic clk,
  input  logic rst_n,
  input  logic op_valid,
  output logic op_ready,
  input  fbs_pkg::op_t op,
  output logic out_valid,
  input  logic out_ready,
  output logic out_landed,
  output logic [23:0] out_weight_sum,
  output logic [31:0] out_value_sum
);
  import fbs_pkg::*;
  // two-entry queue between front and back
  op_t q_r [QDepth];
  logic [1:0] q_cnt_r;
  logic q_wp_r, q_rp_r;
  logic q_pop;
  op_t cur_r;
  back_state_t st_r, st_nxt;
  logic [1:0] k_r;
  logic [AddrBits:0] clr_r;
  logic we;
  logic [AddrBits-1:0] addr;
  logic [EntBits-1:0] wdata, rdata;
  logic [16:0] w;
  logic [24:0] ws;
  logic [40:0] vs;
  logic ov_r, ol_r;
  logic [23:0] ow_r;
  logic [31:0] oval_r;
  // read sums held until the output register is free
  logic [23:0] res_w_r;
  logic [31:0] res_v_r;

  assign op_ready = (q_cnt_r != 2'd2);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
    end else begin
      if (op_valid && op_ready) q_wp_r <= !q_wp_r;
      if (q_pop) q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(op_valid && op_ready) - 2'(q_pop);
    end
    if (op_valid && op_ready) q_r[q_wp_r] <= op;
  end

  always_comb begin
    unique case (k_r)
      2'd0: w = cur_r.w00;
      2'd1: w = cur_r.w01;
      2'd2: w = cur_r.w11;
      default: w = cur_r.w10;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == (AddrBits+1)'(Depth - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (q_cnt_r != 0) begin
        if ((q_r[q_rp_r].splat) || (q_r[q_rp_r].rd && q_r[q_rp_r].valid_addr))
          st_nxt = ST_READ;
        else st_nxt = ST_OUT;
      end
      ST_READ: st_nxt = ST_WRITE;
      ST_WRITE: if (!cur_r.splat || k_r == 2'd3) st_nxt = ST_OUT; else st_nxt = ST_READ;
      ST_OUT: if (!ov_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == ST_IDLE) && (q_cnt_r != 0);
    we = 1'b0;
    addr = cur_r.base;
    wdata = '0;
    ws = 25'(rdata[EntBits-1:VBits]) + 25'(w);
    vs = 41'(rdata[VBits-1:0]) + 41'(w) * 41'(cur_r.pixel);
    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        addr = clr_r[AddrBits-1:0];
      end
      ST_READ, ST_WRITE: begin
        if (cur_r.splat) begin
          unique case (k_r)
            2'd0: addr = cur_r.base;
            2'd1: addr = cur_r.base + AddrBits'(1);
            2'd2: addr = cur_r.base + AddrBits'(StoreCols + 1);
            default: addr = cur_r.base + AddrBits'(StoreCols);
          endcase
        end
        if (st_r == ST_WRITE) begin
          we = cur_r.splat || cur_r.clr;
          if (cur_r.splat) begin
            wdata[EntBits-1:VBits] = ws[24] ? 24'hFFFFFF : ws[23:0];
            wdata[VBits-1:0] = (vs[40:32] != 0) ? 32'hFFFFFFFF : vs[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      k_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + (AddrBits+1)'(1);
      if (st_r == ST_IDLE) k_r <= '0;
      else if (st_r == ST_WRITE) k_r <= k_r + 2'd1;
      if (out_valid && out_ready) ov_r <= 1'b0;
      else if (st_r == ST_OUT && !ov_r) ov_r <= 1'b1;
    end
    if (q_pop) cur_r <= q_r[q_rp_r];
    if (st_r == ST_WRITE && !cur_r.splat) begin
      res_w_r <= rdata[EntBits-1:VBits];
      res_v_r <= rdata[VBits-1:0];
    end else if (st_r == ST_IDLE) begin
      res_w_r <= '0;
      res_v_r <= '0;
    end
    // output register loads only when the previous transaction has left
    if (st_r == ST_OUT && !ov_r) begin
      ol_r <= cur_r.splat;
      ow_r <= res_w_r;
      oval_r <= res_v_r;
    end
  end

  fbs_ram #(.Width(EntBits), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign out_valid = ov_r;
  assign out_landed = ol_r;
  assign out_weight_sum = ow_r;
  assign out_value_sum = oval_r;

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("queue overflow");
  a_noclr_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !ov_r) else $error("output during clear");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ($stable(ol_r) && $stable(ow_r) && $stable(oval_r)))
    else $error("result changed while waiting");
endmodule

>>> rtl/core/forward_bilinear_splat_unit.sv
// forward bilinear splat unit, top level
// splat: stage 1, queue pop, four read-modify-writes on one ram port, then output;
// the back end pops the next transaction only once the current one is in the output register
// read: stage 1, queue pop, read and write states, then output; dropped splat or unused
// command: stage 1, queue pop, output; front holds one transaction and queues two ahead
// synchronous active-low reset; a clearing pass over all 65536 entries then zeroes the store,
// during which up to three transactions are accepted and wait
// depends on fbs_pkg, fbs_if, fbs_front, fbs_back, fbs_ram
module forward_bilinear_splat_unit (
  input  logic clk,
  input  logic rst_n,
  fbs_in_if.sink in_ch,
  fbs_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [fbs_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [fbs_pkg::CfgDataBits-1:0] cfg_data
);
  import fbs_pkg::*;
  logic [8:0] tween_r, width_r, height_r;
  logic [7:0] left_r, top_r;
  logic op_valid, op_ready;
  op_t op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tween_r <= 9'd256;
      left_r <= '0;
      top_r <= '0;
      width_r <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TWEEN: tween_r <= cfg_data;
        REG_LEFT: left_r <= cfg_data[7:0];
        REG_TOP: top_r <= cfg_data[7:0];
        REG_WIDTH: width_r <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fbs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_row(in_ch.row), .in_col(in_ch.col),
    .in_pixel(in_ch.pixel), .in_flow_x(in_ch.flow_x), .in_flow_y(in_ch.flow_y),
    .tween_r(tween_r), .left_r(left_r), .top_r(top_r),
    .width_r(width_r), .height_r(height_r),
    .op_valid(op_valid), .op_ready(op_ready), .op(op)
  );

  fbs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_landed(out_ch.landed), .out_weight_sum(out_ch.weight_sum),
    .out_value_sum(out_ch.value_sum)
  );
endmodule
